@@ rtl/gpe_pkg.sv @@
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared widths, register indexes and elaboration-time helpers for the
// Gaussian population encoder.
// ----------------------------------------------------------------------------
package gpe_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int RANGE_W    = 16;
    localparam int UCNT_W     = 6;
    localparam int ISIG_W     = 16;
    localparam int OFFS_W     = 8;
    localparam int UIDX_W     = 5;
    localparam int ACT_W      = 16;
    localparam int SUM_W      = 22;
    localparam int VAL_W      = 16;
    localparam int V17_W      = 17;
    localparam int SQ_W       = 32;
    localparam int PROD_W     = 48;
    localparam int IDX_SHIFT  = 42;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;

    // shared divider: 17 quotient bits, one per cycle
    localparam int Q_W        = 17;
    localparam int NUM_W      = 33;
    localparam int DCNT_W     = 5;

    localparam int EXP_SERIES_TERMS = 12;

    localparam logic [CFG_IDX_W-1:0] REG_JOINT_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JOINT_RANGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SIGMA_SQ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_OFFSET = 3'd4;

    localparam logic [V17_W-1:0] V17_MAX  = 17'h1FFFF;
    localparam logic [VAL_W-1:0] REF_FULL = 16'd32768;

    typedef logic [ACT_W-1:0] act_t;

    // Ratio between neighbouring table entries, Q0.32, from a truncated series.
    function automatic logic [63:0] exp_ratio(input logic [63:0] step);
        logic [63:0] term;
        logic [63:0] r;
        term = 64'd1 << 32;
        r    = term;
        for (int n = 1; n <= EXP_SERIES_TERMS; n++) begin
            term = ((term * step) >> 32) / 64'(n);
            if (n[0]) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        return r;
    endfunction

    // Table entry k: repeated rounded products of the ratio, rounded to Q0.16.
    function automatic act_t exp_entry(input logic [63:0] ratio, input int k);
        logic [63:0] e;
        logic [63:0] t;
        e = 64'd1 << 32;
        for (int j = 0; j < k; j++) begin
            e = (e * ratio + (64'd1 << 31)) >> 32;
        end
        t = (e + 64'd32768) >> 16;
        return (t > 64'd65535) ? act_t'(16'hFFFF) : t[ACT_W-1:0];
    endfunction

endpackage

@@ rtl/gaussian_population_encoder_core.sv @@
// ----------------------------------------------------------------------------
// gaussian_population_encoder_core
// Population coding of one joint sample with softmax-style normalisation.
// ----------------------------------------------------------------------------
// One sample in, n beats out (n = unit_count clamped to 2..MAX_UNITS), each
// carrying the unit number and its Gaussian activation divided by the sum of
// all activations, the final beat flagged with tlast. The input is held off
// while a sample is being worked on. The sample division is skipped when the
// sample sits at or below joint_min or saturates, and the output divisions are
// skipped when every activation is zero. The one shared restoring divider makes
// one quotient bit a cycle for the normalisation of the sample, the reference
// spacing and each of the n output divisions; the first pass works each unit
// through difference, square, scaling, table index and accumulate.
// Configuration must be written by the user through the plain write port
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module gaussian_population_encoder_core #(
    parameter int MAX_UNITS       = 32,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [gpe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gpe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gpe_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [4:0] unit_index, [20:5] activation, [23:21] zero
    output logic [gpe_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast    // last
);
    import gpe_pkg::*;

    localparam int IDX_W  = $clog2(MAX_UNITS);
    localparam int CNT_W  = $clog2(MAX_UNITS + 1);
    localparam int TAB_AW = $clog2(EXP_TABLE_DEPTH);
    localparam int SCL_W  = IDX_SHIFT + $clog2(EXP_TABLE_DEPTH + 1);
    localparam int PAD_W  = M_TDATA_W - ACT_W - UIDX_W;

    localparam logic [63:0] EXP_STEP  = (64'd1 << 36) / 64'(EXP_TABLE_DEPTH);
    localparam logic [63:0] EXP_RATIO = exp_ratio(EXP_STEP);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_QDIV = 4'd2;
    localparam logic [3:0] S_VAL  = 4'd3;
    localparam logic [3:0] S_RDIV = 4'd4;
    localparam logic [3:0] S_DIFF = 4'd5;
    localparam logic [3:0] S_SQ   = 4'd6;
    localparam logic [3:0] S_PROD = 4'd7;
    localparam logic [3:0] S_IDX  = 4'd8;
    localparam logic [3:0] S_LOOK = 4'd9;
    localparam logic [3:0] S_READ = 4'd10;
    localparam logic [3:0] S_LOAD = 4'd11;
    localparam logic [3:0] S_NDIV = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    // configuration
    logic signed [SAMPLE_W-1:0] joint_min_reg;
    logic [RANGE_W-1:0]         joint_range_reg;
    logic [UCNT_W-1:0]          unit_count_reg;
    logic [ISIG_W-1:0]          inv_sigma_sq_reg;
    logic [OFFS_W-1:0]          value_offset_reg;

    // control
    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              m_tvalid_reg;

    // datapath
    logic signed [SAMPLE_W:0] d_reg;
    logic                     q_zero_reg;
    logic                     q_sat_reg;
    logic [CNT_W-1:0]         nm1_reg;
    logic [VAL_W-1:0]         v_reg;
    logic [VAL_W-1:0]         ref_reg;
    logic [CNT_W-1:0]         racc_reg;
    logic [IDX_W-1:0]         unit_reg;
    logic [VAL_W-1:0]         diff_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [TAB_AW-1:0]        idx_reg;
    logic                     idx_ok_reg;
    logic [ACT_W-1:0]         rd_data_reg;
    logic [ACT_W-1:0]         act_out_reg;
    logic [UIDX_W-1:0]        uidx_out_reg;
    logic                     last_out_reg;

    // shared divider
    logic [SUM_W-1:0] div_rem_reg;
    logic [Q_W-1:0]   div_quo_reg;
    logic [SUM_W-1:0] div_den_reg;
    logic [SUM_W:0]   div_trial;
    logic             div_ge;
    logic [SUM_W-1:0] div_rem_step;
    logic             div_run;
    logic             div_last;
    logic             div_load;
    logic [NUM_W-1:0] div_num;
    logic [SUM_W-1:0] div_den;

    logic [ACT_W-1:0] exp_rom [EXP_TABLE_DEPTH];
    logic [ACT_W-1:0] raw_mem [MAX_UNITS];

    logic                     in_acc;
    logic signed [SAMPLE_W:0] d_next;
    logic [CNT_W-1:0]         n_clamp;
    logic                     d_nonpos;
    logic                     d_ge2;
    logic                     q_direct;
    logic [V17_W:0]           v17_sum;
    logic [V17_W-1:0]         v17;
    logic [CNT_W:0]           racc_sum;
    logic                     racc_wrap;
    logic [SCL_W-1:0]         scaled;
    logic [ACT_W-1:0]         raw_act;
    logic [ACT_W-1:0]         act_calc;
    logic                     unit_last;
    logic                     out_free;
    logic                     out_load;

    for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_exp
        localparam act_t ENTRY = exp_entry(EXP_RATIO, k);
        assign exp_rom[k] = ENTRY;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, act_out_reg, uidx_out_reg};
    assign m_tlast  = last_out_reg;

    assign d_next = $signed({s_tdata[SAMPLE_W-1], s_tdata})
                  - $signed({joint_min_reg[SAMPLE_W-1], joint_min_reg});

    always_comb begin
        if (unit_count_reg < UCNT_W'(2)) begin
            n_clamp = CNT_W'(2);
        end else if (int'(unit_count_reg) > MAX_UNITS) begin
            n_clamp = CNT_W'(MAX_UNITS);
        end else begin
            n_clamp = CNT_W'(unit_count_reg);
        end
    end

    assign d_nonpos = d_reg[SAMPLE_W] || (d_reg == '0);
    // quotient would reach 2.0 or more: saturate without dividing
    assign d_ge2    = {1'b0, d_reg[SAMPLE_W-1:0]} >= {joint_range_reg, 1'b0};
    assign q_direct = d_nonpos || d_ge2;

    assign v17_sum = q_zero_reg ? (V17_W+1)'(value_offset_reg)
                   : {1'b0, div_quo_reg} + (V17_W+1)'(value_offset_reg);
    assign v17     = (q_sat_reg || v17_sum[V17_W]) ? V17_MAX : v17_sum[V17_W-1:0];

    assign racc_sum  = {1'b0, racc_reg} + {1'b0, div_rem_reg[CNT_W-1:0]};
    assign racc_wrap = racc_sum >= {1'b0, nm1_reg};

    assign scaled  = SCL_W'(prod_reg[IDX_SHIFT-1:0]) * SCL_W'(EXP_TABLE_DEPTH);
    assign raw_act = idx_ok_reg ? exp_rom[idx_reg] : '0;

    assign act_calc  = (sum_reg == '0) ? '0
                     : (div_quo_reg[Q_W-1] ? {ACT_W{1'b1}} : div_quo_reg[ACT_W-1:0]);
    assign unit_last = (CNT_W'(unit_reg) == nm1_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (state_reg == S_OUT) && out_free;

    // shared divider: operand select and one restoring step
    assign div_run  = (state_reg == S_QDIV) || (state_reg == S_RDIV)
                   || (state_reg == S_NDIV);
    assign div_last = div_cnt_reg == DCNT_W'(1);
    assign div_load = ((state_reg == S_PREP) && !q_direct) || (state_reg == S_VAL)
                   || ((state_reg == S_LOAD) && (sum_reg != '0));

    always_comb begin
        case (state_reg)
            S_PREP: begin
                div_num = NUM_W'({d_reg[SAMPLE_W-1:0], 16'h0000});
                div_den = SUM_W'(joint_range_reg);
            end
            S_VAL: begin
                div_num = NUM_W'(REF_FULL);
                div_den = SUM_W'(nm1_reg);
            end
            default: begin
                div_num = NUM_W'({rd_data_reg, 16'h0000}) + NUM_W'(sum_reg[SUM_W-1:1]);
                div_den = sum_reg;
            end
        endcase
    end

    assign div_trial    = {div_rem_reg, div_quo_reg[Q_W-1]};
    assign div_ge       = div_trial >= {1'b0, div_den_reg};
    assign div_rem_step = div_ge ? SUM_W'(div_trial - {1'b0, div_den_reg})
                                 : div_trial[SUM_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_PREP;
            S_PREP: state_next = q_direct ? S_VAL : S_QDIV;
            S_QDIV: if (div_last) state_next = S_VAL;
            S_VAL:  state_next = S_RDIV;
            S_RDIV: if (div_last) state_next = S_DIFF;
            S_DIFF: state_next = S_SQ;
            S_SQ:   state_next = S_PROD;
            S_PROD: state_next = S_IDX;
            S_IDX:  state_next = S_LOOK;
            S_LOOK: state_next = unit_last ? S_READ : S_DIFF;
            S_READ: state_next = S_LOAD;
            S_LOAD: state_next = (sum_reg == '0) ? S_OUT : S_NDIV;
            S_NDIV: if (div_last) state_next = S_OUT;
            S_OUT:  if (out_free) state_next = unit_last ? S_IDLE : S_READ;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            joint_min_reg    <= '0;
            joint_range_reg  <= 16'hFFFF;
            unit_count_reg   <= UCNT_W'(2);
            inv_sigma_sq_reg <= ISIG_W'(256);
            value_offset_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_JOINT_MIN:    joint_min_reg    <= cfg_wdata[SAMPLE_W-1:0];
                REG_JOINT_RANGE:  joint_range_reg  <= cfg_wdata[RANGE_W-1:0];
                REG_UNIT_COUNT:   unit_count_reg   <= cfg_wdata[UCNT_W-1:0];
                REG_INV_SIGMA_SQ: inv_sigma_sq_reg <= cfg_wdata[ISIG_W-1:0];
                REG_VALUE_OFFSET: value_offset_reg <= cfg_wdata[OFFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            div_cnt_reg  <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (div_load) begin
                div_cnt_reg <= DCNT_W'(Q_W);
            end else if (div_run) begin
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
            end
            if (state_reg == S_VAL) begin
                sum_reg <= '0;
            end else if (state_reg == S_LOOK) begin
                sum_reg <= sum_reg + SUM_W'(raw_act);
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            d_reg   <= d_next;
            nm1_reg <= n_clamp - CNT_W'(1);
        end
        if (state_reg == S_PREP) begin
            q_zero_reg <= d_nonpos;
            q_sat_reg  <= !d_nonpos && d_ge2;
        end

        if (div_load) begin
            div_rem_reg <= SUM_W'(div_num[NUM_W-1:Q_W]);
            div_quo_reg <= div_num[Q_W-1:0];
            div_den_reg <= div_den;
        end else if (div_run) begin
            div_rem_reg <= div_rem_step;
            div_quo_reg <= {div_quo_reg[Q_W-2:0], div_ge};
        end

        case (state_reg)
            S_VAL: begin
                v_reg    <= v17[V17_W-1:1];
                ref_reg  <= '0;
                racc_reg <= '0;
                unit_reg <= '0;
            end
            S_DIFF: begin
                diff_reg <= (ref_reg > v_reg) ? ref_reg - v_reg : v_reg - ref_reg;
            end
            S_SQ: begin
                sq_reg <= SQ_W'(diff_reg) * SQ_W'(diff_reg);
            end
            S_PROD: begin
                prod_reg <= PROD_W'(sq_reg) * PROD_W'(inv_sigma_sq_reg);
            end
            S_IDX: begin
                // beyond the table range the activation is zero
                idx_ok_reg <= (prod_reg[PROD_W-1:IDX_SHIFT] == '0);
                idx_reg    <= scaled[IDX_SHIFT +: TAB_AW];
            end
            S_LOOK: begin
                // advance the reference point; spacing quotient and remainder
                // stay in the divider until the output pass
                if (unit_last) begin
                    unit_reg <= '0;
                end else begin
                    unit_reg <= unit_reg + IDX_W'(1);
                    if (racc_wrap) begin
                        ref_reg  <= ref_reg + div_quo_reg[VAL_W-1:0] + VAL_W'(1);
                        racc_reg <= CNT_W'(racc_sum - {1'b0, nm1_reg});
                    end else begin
                        ref_reg  <= ref_reg + div_quo_reg[VAL_W-1:0];
                        racc_reg <= racc_sum[CNT_W-1:0];
                    end
                end
            end
            S_OUT: begin
                if (out_free && !unit_last) begin
                    unit_reg <= unit_reg + IDX_W'(1);
                end
            end
            default: ;
        endcase

        if (out_load) begin
            act_out_reg  <= act_calc;
            uidx_out_reg <= UIDX_W'(unit_reg);
            last_out_reg <= unit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_LOOK) begin
            raw_mem[unit_reg] <= raw_act;
        end
        rd_data_reg <= raw_mem[unit_reg];
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a sample is in progress");

    a_div_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        div_run |-> (div_cnt_reg != '0))
        else $error("divider stepping with an exhausted count");

    a_norm_sum_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_NDIV) |-> (sum_reg != '0))
        else $error("output division started with a zero sum");

    a_unit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOOK || state_reg == S_OUT) |-> (CNT_W'(unit_reg) <= nm1_reg))
        else $error("unit index beyond the unit count");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && unit_last) |=> (state_reg == S_IDLE))
        else $error("last beat issued without returning to idle");

endmodule

@@ dv/gaussian_population_encoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// gaussian_population_encoder_core_tb
// Self-checking bench: each joint sample is run through a bit-accurate
// predictor of the normalisation, table lookup and per-unit division, and
// every output beat is checked in order against the predicted or fixed activations.
// A short table of directed rows comes first, then randomised configurations
// with bursty input and a receiver that stalls on its own pattern.
// ----------------------------------------------------------------------------
module gaussian_population_encoder_core_tb;

    import gpe_pkg::*;

    localparam int MAX_UNITS      = 32;
    localparam int EXP_DEPTH      = 256;
    localparam int RAND_PHASES    = 14;
    localparam int HOLD_CYCLES    = 1200;
    // longest quiet stretch of a good run is at most the long hold plus one
    // full 32-unit sample; the limit sits above that
    localparam int WATCHDOG_LIMIT = 6000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_FIXED} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [15:0]          value;      // register data or sample
        logic [ACT_W-1:0]     fix_first;  // fixed activation of unit 0
        logic [ACT_W-1:0]     fix_rest;   // fixed activation of the others
    } dir_row_t;

    typedef struct {
        logic [UIDX_W-1:0] unit;
        logic [ACT_W-1:0]  act;
        logic              last;
    } unit_beat_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    // register shadows, reset values
    logic [15:0] cfg_joint_min    = 16'd0;
    logic [15:0] cfg_joint_range  = 16'd65535;
    logic [5:0]  cfg_unit_count   = 6'd2;
    logic [15:0] cfg_inv_sigma_sq = 16'd256;
    logic [7:0]  cfg_value_offset = 8'd0;

    logic [ACT_W-1:0] gauss_lut [EXP_DEPTH];
    unit_beat_t       pending_beats [$];
    dir_row_t         dir_rows [$];

    int   error_count   = 0;
    int   samples_sent  = 0;
    int   beats_checked = 0;
    int   cfg_writes    = 0;
    int   zero_sum_seen = 0;
    int   units_lo      = MAX_UNITS;
    int   units_hi      = 0;
    int   quiet_cycles  = 0;
    bit   hold_req      = 1'b0;
    unit_beat_t want;

    gaussian_population_encoder_core #(
        .MAX_UNITS       (MAX_UNITS),
        .EXP_TABLE_DEPTH (EXP_DEPTH)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [15:0] sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [4:0] unit_index, [20:5] activation, [23:21] zero
        .m_tlast   (m_tlast)    // last
    );

    always #4 aclk = ~aclk;

    // exp(-x) table over x in [0,16): ratio from a truncated series, then
    // repeated rounded products in Q0.32
    initial begin
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] ratio;
        logic [63:0] e;
        logic [63:0] t;
        step  = (64'd1 << 36) / EXP_DEPTH;
        term  = 64'd1 << 32;
        ratio = term;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * step) >> 32) / n;
            if (n % 2 == 1) begin
                ratio = ratio - term;
            end else begin
                ratio = ratio + term;
            end
        end
        e = 64'd1 << 32;
        for (int k = 0; k < EXP_DEPTH; k++) begin
            t = (e + 64'd32768) >> 16;
            gauss_lut[k] = (t > 64'd65535) ? 16'hFFFF : t[15:0];
            e = (e * ratio + (64'd1 << 31)) >> 32;
        end
    end

    // append one expected beat to the scoreboard
    function automatic void expect_beat(input unit_beat_t b);
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    // append one row to the directed table
    function automatic void add_row(input dir_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic int active_units();
        int n;
        n = int'(cfg_unit_count);
        if (n < 2) begin
            n = 2;
        end
        if (n > MAX_UNITS) begin
            n = MAX_UNITS;
        end
        return n;
    endfunction

    function automatic void predict_activations(input logic [15:0] smp_bits);
        int          d;
        int          n;
        logic [63:0] q;
        logic [63:0] v17;
        logic [63:0] v;
        logic [63:0] rp;
        logic [63:0] diff;
        logic [63:0] sq;
        logic [63:0] idx;
        logic [63:0] act;
        logic [15:0] raw [MAX_UNITS];
        logic [21:0] total;
        unit_beat_t  b;
        d = int'($signed(smp_bits)) - int'($signed(cfg_joint_min));
        if (d <= 0) begin
            q = 64'd0;
        end else if (cfg_joint_range == 16'd0) begin
            q = 64'd131071;
        end else begin
            q = (64'(d) << 16) / cfg_joint_range;
        end
        v17 = q + cfg_value_offset;
        if (v17 > 64'd131071) begin
            v17 = 64'd131071;
        end
        v = v17 >> 1;
        n = active_units();
        units_lo = (n < units_lo) ? n : units_lo;
        units_hi = (n > units_hi) ? n : units_hi;
        total = '0;
        for (int i = 0; i < n; i++) begin
            rp   = (64'(i) * 32768) / (n - 1);
            diff = (rp > v) ? rp - v : v - rp;
            sq   = diff * diff;
            idx  = (sq * cfg_inv_sigma_sq * EXP_DEPTH) >> 42;
            raw[i] = (idx < EXP_DEPTH) ? gauss_lut[int'(idx)] : 16'd0;
            total  = total + raw[i];
        end
        if (total == '0) begin
            zero_sum_seen++;
        end
        for (int i = 0; i < n; i++) begin
            act = 64'd0;
            if (total != '0) begin
                act = (64'(raw[i]) * 65536 + (total >> 1)) / total;
                if (act > 64'd65535) begin
                    act = 64'd65535;
                end
            end
            b.unit = i[UIDX_W-1:0];
            b.act  = act[ACT_W-1:0];
            b.last = (i == n - 1);
            expect_beat(b);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        error_count++;
        if (error_count <= 60) begin
            $display("MISMATCH @%0t %s: got %0d, expected %0d", $time, what, got, exp_val);
        end
    endtask

    // offer one sample and hold until the beat is taken
    task automatic offer_sample(input logic [15:0] smp);
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    task automatic drain_and_pause();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_JOINT_MIN:    cfg_joint_min    = val;
            REG_JOINT_RANGE:  cfg_joint_range  = val;
            REG_UNIT_COUNT:   cfg_unit_count   = val[5:0];
            REG_INV_SIGMA_SQ: cfg_inv_sigma_sq = val;
            REG_VALUE_OFFSET: cfg_value_offset = val[7:0];
            default: ;  // unmapped index: drop
        endcase
        cfg_writes++;
    endtask

    function automatic dir_row_t wr_row(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        dir_row_t r;
        r = '{ROW_WRITE, idx, val, 16'd0, 16'd0};
        return r;
    endfunction

    function automatic dir_row_t smp_row(input logic [15:0] val);
        dir_row_t r;
        r = '{ROW_SAMPLE, REG_JOINT_MIN, val, 16'd0, 16'd0};
        return r;
    endfunction

    function automatic dir_row_t fix_row(input logic [15:0] val, input logic [15:0] first,
                                         input logic [15:0] rest);
        dir_row_t r;
        r = '{ROW_FIXED, REG_JOINT_MIN, val, first, rest};
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("beat with nothing expected, unit", int'(m_tdata[4:0]), -1);
            end else begin
                want = pending_beats.pop_front();
                if (m_tdata[UIDX_W-1:0] !== want.unit) begin
                    report_mismatch("unit_index", int'(m_tdata[UIDX_W-1:0]), int'(want.unit));
                end
                if (m_tdata[UIDX_W +: ACT_W] !== want.act) begin
                    report_mismatch("activation", int'(m_tdata[UIDX_W +: ACT_W]), int'(want.act));
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("tlast", int'(m_tlast), int'(want.last));
                end
                if (m_tdata[M_TDATA_W-1:UIDX_W+ACT_W] !== '0) begin
                    report_mismatch("tdata padding", int'(m_tdata[M_TDATA_W-1:UIDX_W+ACT_W]), 0);
                end
                beats_checked++;
            end
        end
    end

    // receiver: stretches of steady, light and heavy stalling, plus one long hold
    initial begin
        int mode;
        int stretch;
        int held;
        mode    = 0;
        stretch = 0;
        held    = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                held++;
                if (held >= HOLD_CYCLES) begin
                    hold_req = 1'b0;
                    held     = 0;
                end
            end else begin
                if (stretch == 0) begin
                    mode    = $urandom_range(0, 2);
                    stretch = $urandom_range(16, 160);
                end
                stretch--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat for %0d cycles, %0d beats outstanding",
                     quiet_cycles, pending_beats.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          phase;
        int          items;
        int          burst;
        int          idle_style;
        int          lo;
        int          s_int;
        int          r;
        int          n;
        logic [15:0] jm;
        logic [15:0] jr;
        logic [15:0] is;
        logic [15:0] smp;
        logic [5:0]  uc;
        logic [7:0]  vo;
        unit_beat_t  b;

        // reset values, extremes of the sample
        add_row(smp_row(16'd0));
        add_row(smp_row(16'd8000));
        add_row(smp_row(16'h8000));              // below joint_min
        add_row(smp_row(16'h7FFF));
        add_row(smp_row(16'hAAAA));
        // narrow Gaussians with two units
        add_row(wr_row(REG_INV_SIGMA_SQ, 16'hFFFF));
        add_row(fix_row(16'h8000, 16'hFFFF, 16'd0)); // v held at zero
        add_row(fix_row(16'h7FFF, 16'd0, 16'd0));    // midway, all zero
        add_row(wr_row(REG_JOINT_RANGE, 16'd1));
        add_row(fix_row(16'h7FFF, 16'd0, 16'd0));    // v saturated high
        add_row(wr_row(REG_JOINT_RANGE, 16'd0));
        add_row(fix_row(16'd1, 16'd0, 16'd0));       // zero range, above
        add_row(fix_row(16'd0, 16'hFFFF, 16'd0));    // zero range, at min
        // widest setting with the largest offset
        add_row(wr_row(REG_JOINT_MIN, 16'h8000));
        add_row(wr_row(REG_JOINT_RANGE, 16'hFFFF));
        add_row(wr_row(REG_INV_SIGMA_SQ, 16'd256));
        add_row(wr_row(REG_VALUE_OFFSET, 16'h00FF));
        add_row(wr_row(REG_UNIT_COUNT, 16'd32));
        add_row(smp_row(16'h8000));
        add_row(smp_row(16'h7FFF));
        add_row(smp_row(16'd0));
        // unit counts outside 2..32 clamp
        add_row(wr_row(REG_UNIT_COUNT, 16'd0));
        add_row(smp_row(16'd1000));
        add_row(wr_row(REG_UNIT_COUNT, 16'd1));
        add_row(smp_row(16'hB1E0));
        add_row(wr_row(REG_UNIT_COUNT, 16'd63));
        add_row(smp_row(16'd20000));
        // unmapped indexes must leave the registers alone
        add_row(wr_row(REG_SPARE_5, 16'hFFFF));
        add_row(wr_row(REG_SPARE_6, 16'hFFFF));
        add_row(wr_row(REG_SPARE_7, 16'hFFFF));
        add_row(smp_row(16'd4321));
        add_row(wr_row(REG_INV_SIGMA_SQ, 16'd1));
        add_row(smp_row(16'd12345));
        // top of the joint range, offset on and off
        add_row(wr_row(REG_JOINT_MIN, 16'h7FFF));
        add_row(wr_row(REG_JOINT_RANGE, 16'd1));
        add_row(wr_row(REG_UNIT_COUNT, 16'd4));
        add_row(wr_row(REG_INV_SIGMA_SQ, 16'd4096));
        add_row(smp_row(16'h7FFF));
        add_row(smp_row(16'hFFFF));
        add_row(wr_row(REG_VALUE_OFFSET, 16'd0));
        add_row(smp_row(16'h7FFF));
        add_row(wr_row(REG_UNIT_COUNT, 16'hFFC3));   // upper bits ignored
        add_row(smp_row(16'h7FFF));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_WRITE: begin
                    drain_and_pause();
                    write_register(dir_rows[i].reg_idx, dir_rows[i].value);
                end
                ROW_SAMPLE: begin
                    offer_sample(dir_rows[i].value);
                    predict_activations(dir_rows[i].value);
                end
                default: begin
                    offer_sample(dir_rows[i].value);
                    n = active_units();
                    for (int u = 0; u < n; u++) begin
                        b.unit = u[UIDX_W-1:0];
                        b.act  = (u == 0) ? dir_rows[i].fix_first : dir_rows[i].fix_rest;
                        b.last = (u == n - 1);
                        expect_beat(b);
                    end
                end
            endcase
        end

        // back-pressure: hold the output while samples keep coming
        drain_and_pause();
        write_register(REG_UNIT_COUNT, 16'd8);
        hold_req = 1'b1;
        repeat (5) begin
            smp = 16'($urandom);
            offer_sample(smp);
            predict_activations(smp);
        end

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: begin
                    jm = 16'h8000; jr = 16'hFFFF; uc = 6'd2;  is = 16'hFFFF; vo = 8'd0;
                end
                1: begin
                    jm = 16'h7FFF; jr = 16'd1;    uc = 6'd32; is = 16'd1;    vo = 8'hFF;
                end
                2: begin
                    jm = 16'hC000; jr = 16'd0;    uc = 6'd0;  is = 16'd0;    vo = 8'd128;
                end
                default: begin
                    jm = 16'($urandom);
                    jr = 16'($urandom_range(1, 65535) >> $urandom_range(0, 12));
                    r  = $urandom_range(0, 19);
                    if (r < 13) begin
                        uc = 6'($urandom_range(2, 8));
                    end else if (r < 18) begin
                        uc = 6'($urandom_range(9, 20));
                    end else begin
                        uc = 6'($urandom_range(0, 63));
                    end
                    is = 16'($urandom_range(1, 65535) >> $urandom_range(0, 15));
                    vo = 8'($urandom);
                end
            endcase
            drain_and_pause();
            write_register(REG_JOINT_MIN, jm);
            write_register(REG_JOINT_RANGE, jr);
            write_register(REG_UNIT_COUNT, {10'd0, uc});
            write_register(REG_INV_SIGMA_SQ, is);
            write_register(REG_VALUE_OFFSET, {8'd0, vo});

            lo         = int'($signed(jm));
            items      = $urandom_range(18, 26);
            idle_style = $urandom_range(0, 2);
            burst      = (idle_style == 0) ? items : $urandom_range(1, 6);
            for (int k = 0; k < items; k++) begin
                r = $urandom_range(0, 19);
                if (r < 14) begin
                    s_int = lo + int'($urandom_range(0, jr));
                end else if (r < 17) begin
                    s_int = int'($urandom);
                end else begin
                    case ($urandom_range(0, 4))
                        0:       s_int = lo;
                        1:       s_int = lo + int'(jr);
                        2:       s_int = lo - 1;
                        3:       s_int = -32768;
                        default: s_int = 32767;
                    endcase
                end
                smp = 16'(s_int);
                offer_sample(smp);
                predict_activations(smp);
                burst--;
                if (burst <= 0 && k != items - 1) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, (idle_style == 1) ? 4 : 40)) @(posedge aclk);
                    burst = $urandom_range(1, 6);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (60) @(posedge aclk);

        $display("Covered %0d samples, %0d beats checked, %0d register writes.",
                 samples_sent, beats_checked, cfg_writes);
        $display("Unit counts %0d to %0d in use; %0d samples with every activation zero.",
                 units_lo, units_hi, zero_sum_seen);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/gpe_pkg.sv
rtl/gaussian_population_encoder_core.sv
dv/gaussian_population_encoder_core_tb.sv
